[design/assert_macros.svh]
// Assertion helpers. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge out of reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

[design/cltt_pkg.sv]
package cltt_pkg;

    localparam int ROWS_DEF = 2;
    localparam int COLS_DEF = 20;

    localparam int NREGS     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW2 = 2'd2;

    localparam logic [7:0] ROW0_CMD_RST = 8'h80;
    localparam logic [7:0] ROW1_CMD_RST = 8'hC0;
    localparam logic [7:0] ROW2_CMD_RST = 8'h94;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CMD_CLEAR = 8'h01;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_READ,
        ST_DATA,
        ST_FF,
        ST_MOVE
    } cltt_state_t;

    typedef struct packed {
        logic store_char;   // write char at cursor if row not full
        logic clear_all;    // form feed: blank store, home cursor
        logic start_dump;   // latch newline flag, row counter to 0
        logic load_cmd;     // row start command into output register
        logic issue_read;   // read store at dump position
        logic load_data;    // read data into output register
        logic load_ff;      // clear command into output register
        logic next_col;
        logic next_row;
        logic move_down;    // cursor down or scroll
    } cltt_cmd_t;

    typedef struct packed {
        logic is_nl;
        logic is_cr;
        logic is_ff;
        logic out_free;
        logic col_last;
        logic row_last;
    } cltt_status_t;

endpackage

[design/cltt_ctrl.sv]
module cltt_ctrl
    import cltt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  cltt_status_t status,
    output cltt_cmd_t    cmd
);

    cltt_state_t state_reg;
    cltt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        char_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                char_stall = 1'b0;
                if (char_valid)
                begin
                    priority if (status.is_nl || status.is_cr)
                    begin
                        cmd.start_dump = 1'b1;
                        state_next     = ST_CMD;
                    end
                    else if (status.is_ff)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_FF;
                    end
                    else
                    begin
                        cmd.store_char = 1'b1;
                    end
                end
            end
            ST_CMD:
            begin
                if (status.out_free)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.issue_read = 1'b1;
                state_next     = ST_DATA;
            end
            ST_DATA:
            begin
                if (status.out_free)
                begin
                    cmd.load_data = 1'b1;
                    priority if (!status.col_last)
                    begin
                        cmd.next_col = 1'b1;
                        state_next   = ST_READ;
                    end
                    else if (!status.row_last)
                    begin
                        cmd.next_row = 1'b1;
                        state_next   = ST_CMD;
                    end
                    else
                    begin
                        state_next = ST_MOVE;
                    end
                end
            end
            ST_FF:
            begin
                if (status.out_free)
                begin
                    cmd.load_ff = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                cmd.move_down = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/cltt_datapath.sv]
module cltt_datapath
    import cltt_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           char_code,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  cltt_cmd_t            cmd,
    output cltt_status_t         status,
    output logic                 lcd_valid,
    input  logic                 lcd_stall,
    output logic [7:0]           lcd_byte,
    output logic                 register_select,
    output logic                 last_of_run
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int CI_W   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);
    localparam logic [COL_W-1:0] COL_FULL = COL_W'(COLS);

    // screen rows live in a ring: logical row r sits in physical row (r + base) mod ROWS
    logic [7:0]       screen_mem [DEPTH];
    logic [COLS-1:0]  valid_reg  [ROWS];
    logic [COLS-1:0]  valid_next [ROWS];

    logic [7:0]       start_cmd_reg [NREGS];
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] base_reg, base_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic             nl_reg, nl_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_rs_reg, out_rs_next;
    logic             out_last_reg, out_last_next;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    logic [ROW_W-1:0]  wr_prow;
    logic [ROW_W-1:0]  rd_prow;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    assign wr_prow = phys_row(cur_row_reg, base_reg);
    assign rd_prow = phys_row(row_cnt_reg, base_reg);
    assign wr_addr = ADDR_W'(wr_prow) * ADDR_W'(COLS) + ADDR_W'(cur_col_reg[CI_W-1:0]);
    assign rd_addr = ADDR_W'(rd_prow) * ADDR_W'(COLS) + ADDR_W'(col_cnt_reg[CI_W-1:0]);
    assign wr_en   = cmd.store_char && (cur_col_reg < COL_FULL);

    assign status.is_nl    = (char_code == CH_NL);
    assign status.is_cr    = (char_code == CH_CR);
    assign status.is_ff    = (char_code == CH_FF);
    assign status.out_free = !out_valid_reg || !lcd_stall;
    assign status.col_last = (col_cnt_reg == COL_LAST);
    assign status.row_last = (row_cnt_reg == ROW_LAST);

    assign lcd_valid       = out_valid_reg;
    assign lcd_byte        = out_byte_reg;
    assign register_select = out_rs_reg;
    assign last_of_run     = out_last_reg;

    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        base_next    = base_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        nl_next      = nl_reg;
        valid_next   = valid_reg;

        if (wr_en)
        begin
            valid_next[wr_prow][cur_col_reg[CI_W-1:0]] = 1'b1;
            cur_col_next = cur_col_reg + COL_W'(1);
        end
        if (cmd.clear_all)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                valid_next[r] = '0;
            end
            cur_row_next = '0;
            cur_col_next = '0;
        end
        if (cmd.start_dump)
        begin
            nl_next      = status.is_nl;
            row_cnt_next = '0;
        end
        if (cmd.load_cmd)
        begin
            col_cnt_next = '0;
        end
        if (cmd.next_col)
        begin
            col_cnt_next = col_cnt_reg + COL_W'(1);
        end
        if (cmd.next_row)
        begin
            row_cnt_next = row_cnt_reg + ROW_W'(1);
        end
        if (cmd.move_down)
        begin
            if (nl_reg)
            begin
                cur_col_next = '0;
            end
            if (cur_row_reg < ROW_LAST)
            begin
                cur_row_next = cur_row_reg + ROW_W'(1);
            end
            else
            begin
                // old top row becomes the blank bottom row
                valid_next[base_reg] = '0;
                base_next = (base_reg == ROW_LAST) ? '0 : base_reg + ROW_W'(1);
            end
        end
    end

    always_comb
    begin
        out_byte_next  = out_byte_reg;
        out_rs_next    = out_rs_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && lcd_stall;
        priority if (cmd.load_cmd)
        begin
            out_byte_next  = start_cmd_reg[CFG_IDX_W'(row_cnt_reg)];
            out_rs_next    = RS_CMD;
            out_last_next  = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (cmd.load_data)
        begin
            out_byte_next  = rd_valid_reg ? rd_data_reg : CH_SPACE;
            out_rs_next    = RS_DATA;
            out_last_next  = status.row_last && status.col_last;
            out_valid_next = 1'b1;
        end
        else if (cmd.load_ff)
        begin
            out_byte_next  = CMD_CLEAR;
            out_rs_next    = RS_CMD;
            out_last_next  = 1'b1;
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && lcd_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            screen_mem[wr_addr] <= char_code;
        end
        if (cmd.issue_read)
        begin
            rd_data_reg  <= screen_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_prow][col_cnt_reg[CI_W-1:0]];
        end
        out_byte_reg <= out_byte_next;
        out_rs_reg   <= out_rs_next;
        out_last_reg <= out_last_next;
        row_cnt_reg  <= row_cnt_next;
        col_cnt_reg  <= col_cnt_next;
        nl_reg       <= nl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cmd_reg[CFG_IDX_ROW0] <= ROW0_CMD_RST;
            start_cmd_reg[CFG_IDX_ROW1] <= ROW1_CMD_RST;
            start_cmd_reg[CFG_IDX_ROW2] <= ROW2_CMD_RST;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                valid_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && (cfg_index < CFG_IDX_W'(NREGS)))
            begin
                start_cmd_reg[cfg_index] <= cfg_data;
            end
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

endmodule

[design/char_lcd_text_terminal.sv]
// Printable char: stored at the cursor, no output. Form feed: one clear command.
// Newline / carriage return: each row goes out as its start command, then its data bytes;
// each data byte is read from the screen memory, then loaded into the output register.
// The first LCD write after a newline is the row start command, once the output is free.
// Reset (async, active low): row start commands to defaults, cursor home, store reads as
// spaces through per-entry valid bits cleared at once; no clearing pass.
`include "assert_macros.svh"

module char_lcd_text_terminal
    import cltt_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  logic [7:0]           char_code,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 lcd_valid,
    input  logic                 lcd_stall,
    output logic [7:0]           lcd_byte,
    output logic                 register_select,
    output logic                 last_of_run
);

    cltt_cmd_t    cmd;
    cltt_status_t status;

    // the user must write registers only while idle (the block does not enforce it), so writes never wait
    assign cfg_ready = 1'b1;

    cltt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .status     (status),
        .cmd        (cmd)
    );

    cltt_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_code       (char_code),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status),
        .lcd_valid       (lcd_valid),
        .lcd_stall       (lcd_stall),
        .lcd_byte        (lcd_byte),
        .register_select (register_select),
        .last_of_run     (last_of_run)
    );

    `ASSERT_HOLDS(a_single_load, clk, rst_n, $onehot0({cmd.load_cmd, cmd.load_data, cmd.load_ff}), "two output loads at once")
    `ASSERT_IMPLIES(a_load_when_free, clk, rst_n, (cmd.load_cmd || cmd.load_data || cmd.load_ff), status.out_free, "output register overwritten")
    `ASSERT_IMPLIES(a_idle_quiet, clk, rst_n, !char_stall, !(cmd.load_cmd || cmd.load_data || cmd.issue_read || cmd.load_ff || cmd.move_down), "dump activity while taking chars")
    `ASSERT_NEXT(a_dump_blocks, clk, rst_n, cmd.start_dump, (char_stall && !cmd.store_char), "char taken during dump")

endmodule
